>>> sv/iibm_pkg.sv
// iibm_pkg: shared types and constants for the integral image box mean core
// no dependencies
package iibm_pkg;

	localparam int MAX_WIDTH_D  = 256;
	localparam int MAX_HEIGHT_D = 256;
	localparam int PIXEL_BITS_D = 8;

	localparam int TABLE_BITS  = 24;
	localparam int ROWSUM_BITS = 16;
	localparam int SIZE_BITS   = 9;
	localparam int MEAN_BITS   = 16;
	localparam int THR_BITS    = 16;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_LOW_THR      = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_THR     = 2'd3;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic load_step;   // write one pixel (table write)
		logic q_capture;   // latch query and check
		logic rd_issue;    // issue a corner read
		logic [1:0] rd_sel;
		logic rd_take;     // accumulate read data
		logic div_start;
		logic emit;
	} iibm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic q_error;
		logic div_done;
	} iibm_stat_t;

endpackage

>>> sv/integral_image_box_mean_core.sv
// integral_image_box_mean_core: summed-area table box mean top level
// depends on iibm_pkg, iibm_ctrl, iibm_dp, iibm_ram
//
// usage
//   start/busy command channel: an item transfers on a rising edge with start
//   high and busy low. func low loads the next raster pixel, func high asks a
//   box query on box_x, box_y, box_width, box_height.
//   a load reads the table entry above, then writes the new entry.
//   a query raises its result strobe on the error-free path after the check,
//   four corner reads on the single read port and the 32-step restoring
//   divider, or after the check alone on error; result_valid marks it for
//   one cycle, no stall possible.
//   config: cfg_valid/cfg_ready, cfg_ready equals not busy; a size write
//   restarts loading at pixel zero and clears the loaded flag.
//   reset: registers take their defaults, no image is loaded; the table
//   holds no defined data until a full image has been loaded.
module integral_image_box_mean_core #(
	parameter int MAX_WIDTH  = iibm_pkg::MAX_WIDTH_D,
	parameter int MAX_HEIGHT = iibm_pkg::MAX_HEIGHT_D,
	parameter int PIXEL_BITS = iibm_pkg::PIXEL_BITS_D
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               func,
	input  logic [PIXEL_BITS-1:0]              pixel_value,
	input  logic [7:0]                         box_x,
	input  logic [7:0]                         box_y,
	input  logic [8:0]                         box_width,
	input  logic [8:0]                         box_height,
	output logic                               result_valid,
	output logic [iibm_pkg::MEAN_BITS-1:0]     box_mean,
	output logic                               in_band,
	output logic                               query_error,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [iibm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [iibm_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import iibm_pkg::*;

	iibm_cmd_t  cmd;
	iibm_stat_t stat;

	assign cfg_ready = !busy;

	iibm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .func(func),
		.stat(stat), .cmd(cmd), .busy(busy)
	);

	iibm_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
		.PIXEL_BITS(PIXEL_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .stat(stat), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .pixel_value(pixel_value), .box_x(box_x),
		.box_y(box_y), .box_width(box_width), .box_height(box_height),
		.box_mean(box_mean), .in_band(in_band), .query_error(query_error),
		.result_valid(result_valid)
	);
endmodule

>>> sv/iibm_ram.sv
// iibm_ram: generic single port write, single port read RAM with registered read
// no dependencies
module iibm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

>>> sv/iibm_ctrl.sv
// iibm_ctrl: controller state machine for loads and box queries
// depends on iibm_pkg
module iibm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               func,
	input  iibm_pkg::iibm_stat_t stat,
	output iibm_pkg::iibm_cmd_t  cmd,
	output logic               busy
);
	import iibm_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOAD  = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

	logic [2:0] state_q, state_d;
	logic [2:0] cnt_q, cnt_d;

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (func == FUNC_LOAD) begin
						state_d = ST_LOAD;
					end else begin
						cmd.q_capture = 1'b1;
						state_d = ST_CHECK;
					end
				end
			end
			ST_LOAD: begin
				// above entry read was issued on accept; write now
				cmd.load_step = 1'b1;
				state_d = ST_IDLE;
			end
			ST_CHECK: begin
				if (stat.q_error) begin
					state_d = ST_EMIT;
				end else begin
					cmd.rd_issue = 1'b1;
					cmd.rd_sel = 2'd0;
					cnt_d = 3'd1;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_take = 1'b1;
				cmd.rd_sel = cnt_q[1:0] - 2'd1;
				if (cnt_q == 3'd4) begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV;
				end else begin
					cmd.rd_issue = 1'b1;
					cmd.rd_sel = cnt_q[1:0];
					cnt_d = cnt_q + 3'd1;
				end
			end
			ST_DIV: begin
				if (stat.div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end
endmodule

>>> sv/iibm_dp.sv
// iibm_dp: datapath with table store, load position, corner sum and divider
// depends on iibm_pkg and iibm_ram
module iibm_dp #(
	parameter int MAX_WIDTH  = iibm_pkg::MAX_WIDTH_D,
	parameter int MAX_HEIGHT = iibm_pkg::MAX_HEIGHT_D,
	parameter int PIXEL_BITS = iibm_pkg::PIXEL_BITS_D
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  iibm_pkg::iibm_cmd_t           cmd,
	output iibm_pkg::iibm_stat_t          stat,
	input  logic                          cfg_valid,
	input  logic [iibm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [iibm_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic [PIXEL_BITS-1:0]         pixel_value,
	input  logic [7:0]                    box_x,
	input  logic [7:0]                    box_y,
	input  logic [8:0]                    box_width,
	input  logic [8:0]                    box_height,
	output logic [iibm_pkg::MEAN_BITS-1:0] box_mean,
	output logic                          in_band,
	output logic                          query_error,
	output logic                          result_valid
);
	import iibm_pkg::*;

	localparam int CB = $clog2(MAX_WIDTH);
	localparam int RB = $clog2(MAX_HEIGHT);
	localparam int AB = CB + RB;
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int NUM_BITS = TABLE_BITS + 8;
	localparam int DEN_BITS = 2 * SIZE_BITS;
	localparam int DCNT_BITS = $clog2(NUM_BITS + 1);

	// configuration
	logic [SIZE_BITS-1:0] width_q, height_q;
	logic [THR_BITS-1:0]  low_q, high_q;
	logic                 size_wr;

	assign size_wr = cfg_valid && !busy &&
		(cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= SIZE_BITS'(256);
			height_q <= SIZE_BITS'(256);
			low_q <= THR_BITS'(13);
			high_q <= THR_BITS'(205);
		end else if (cfg_valid && !busy) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q <= cfg_data[SIZE_BITS-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[SIZE_BITS-1:0];
				REG_LOW_THR:      low_q <= cfg_data[THR_BITS-1:0];
				REG_HIGH_THR:     high_q <= cfg_data[THR_BITS-1:0];
				default: ;
			endcase
		end
	end

	// effective image size
	logic [12:0] iw, ih;
	always_comb begin
		if (width_q == '0) iw = 13'd1;
		else if ({4'd0, width_q} > 13'(MAX_WIDTH)) iw = 13'(MAX_WIDTH);
		else iw = {4'd0, width_q};
		if (height_q == '0) ih = 13'd1;
		else if ({4'd0, height_q} > 13'(MAX_HEIGHT)) ih = 13'(MAX_HEIGHT);
		else ih = {4'd0, height_q};
	end

	// load position
	logic [12:0] col_q, row_q;
	logic [ROWSUM_BITS-1:0] rowsum_q;
	logic loaded_q;
	logic [PIXEL_BITS-1:0] pix_q;
	logic [12:0] lc, lr;
	logic restart;
	logic [ROWSUM_BITS-1:0] rs_new;
	logic load_acc;

	assign load_acc = start && !busy && cmd.q_capture == 1'b0;
	assign restart = (col_q >= iw) || (row_q >= ih);
	assign lc = restart ? 13'd0 : col_q;
	assign lr = restart ? 13'd0 : row_q;

	// table ram
	logic          ram_we, ram_re;
	logic [AB-1:0] waddr, raddr;
	logic [TABLE_BITS-1:0] wdata, rdata;
	logic [12:0] lc_s1, lr_s1;

	iibm_ram #(.WIDTH(TABLE_BITS), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .waddr(waddr), .wdata(wdata),
		.re(ram_re), .raddr(raddr), .rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (load_acc) begin
			pix_q <= pixel_value;
			lc_s1 <= lc;
			lr_s1 <= lr;
		end
	end

	assign rs_new = ((lc_s1 == 13'd0) ? ROWSUM_BITS'(0) : rowsum_q)
		+ ROWSUM_BITS'(pix_q);
	assign ram_we = cmd.load_step;
	assign waddr = {lr_s1[RB-1:0], lc_s1[CB-1:0]};
	assign wdata = ((lr_s1 == 13'd0) ? TABLE_BITS'(0) : rdata) + TABLE_BITS'(rs_new);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			rowsum_q <= '0;
			loaded_q <= 1'b0;
		end else if (size_wr) begin
			col_q <= '0;
			row_q <= '0;
			rowsum_q <= '0;
			loaded_q <= 1'b0;
		end else if (cmd.load_step) begin
			rowsum_q <= rs_new;
			if (lc_s1 + 13'd1 >= iw) begin
				col_q <= '0;
				if (lr_s1 + 13'd1 >= ih) begin
					row_q <= '0;
					loaded_q <= 1'b1;
				end else begin
					row_q <= lr_s1 + 13'd1;
					if (lc_s1 == 13'd0 && lr_s1 == 13'd0) loaded_q <= 1'b0;
				end
			end else begin
				col_q <= lc_s1 + 13'd1;
				if (lc_s1 == 13'd0 && lr_s1 == 13'd0) loaded_q <= 1'b0;
			end
		end
	end

	// query capture
	logic [12:0] bx_q, by_q, r2_q, c2_q;
	logic [SIZE_BITS-1:0] aw_q, ah_q;
	logic err_q;
	always_ff @(posedge clk) begin
		if (cmd.q_capture) begin
			bx_q <= {5'd0, box_x};
			by_q <= {5'd0, box_y};
			r2_q <= {5'd0, box_y} + {4'd0, box_height} - 13'd2;
			c2_q <= {5'd0, box_x} + {4'd0, box_width} - 13'd2;
			aw_q <= box_width - SIZE_BITS'(2);
			ah_q <= box_height - SIZE_BITS'(2);
			err_q <= (box_width <= 9'd2) || (box_height <= 9'd2) ||
				({5'd0, box_x} + {4'd0, box_width} > iw) ||
				({5'd0, box_y} + {4'd0, box_height} > ih) || !loaded_q;
		end
	end
	assign stat.q_error = err_q;

	// corner reads: 0 (r2,c2) +, 1 (by,c2) -, 2 (r2,bx) -, 3 (by,bx) +
	logic [12:0] rr, rc;
	always_comb begin
		unique case (cmd.rd_sel)
			2'd0: begin rr = r2_q; rc = c2_q; end
			2'd1: begin rr = by_q; rc = c2_q; end
			2'd2: begin rr = r2_q; rc = bx_q; end
			default: begin rr = by_q; rc = bx_q; end
		endcase
	end
	assign ram_re = load_acc || cmd.rd_issue;
	always_comb begin
		if (cmd.rd_issue) raddr = {rr[RB-1:0], rc[CB-1:0]};
		else raddr = {lr[RB-1:0] - RB'(1), lc[CB-1:0]};
	end

	// corner of the read data now on rdata
	logic [1:0] take_sel_s1;
	always_ff @(posedge clk) begin
		if (cmd.rd_issue) take_sel_s1 <= cmd.rd_sel;
	end

	logic [TABLE_BITS-1:0] acc_q;
	always_ff @(posedge clk) begin
		if (cmd.q_capture) begin
			acc_q <= '0;
		end else if (cmd.rd_take) begin
			if (take_sel_s1 == 2'd1 || take_sel_s1 == 2'd2) acc_q <= acc_q - rdata;
			else acc_q <= acc_q + rdata;
		end
	end

	// restoring divider, one quotient bit per cycle
	logic [NUM_BITS-1:0] quo_q;
	logic [DEN_BITS:0]   rem_q;
	logic [DEN_BITS-1:0] den_q;
	logic [DCNT_BITS-1:0] dcnt_q;
	logic div_run_q;
	logic [DEN_BITS:0] rem_sh;
	logic [DEN_BITS-1:0] area_s1;

	always_ff @(posedge clk) begin
		if (cmd.q_capture) area_s1 <= '0;
		else if (cmd.rd_take && take_sel_s1 == 2'd0) area_s1 <= aw_q * ah_q;
	end

	assign rem_sh = {rem_q[DEN_BITS-1:0], quo_q[NUM_BITS-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_run_q <= 1'b0;
			dcnt_q <= '0;
		end else if (cmd.div_start) begin
			div_run_q <= 1'b1;
			dcnt_q <= DCNT_BITS'(NUM_BITS);
		end else if (div_run_q) begin
			dcnt_q <= dcnt_q - DCNT_BITS'(1);
			if (dcnt_q == DCNT_BITS'(1)) div_run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			quo_q <= {(take_sel_s1 == 2'd3) ? acc_q + rdata : acc_q, 8'd0};
			rem_q <= '0;
			den_q <= area_s1;
		end else if (div_run_q) begin
			if (rem_sh >= {1'b0, den_q}) begin
				rem_q <= rem_sh - {1'b0, den_q};
				quo_q <= {quo_q[NUM_BITS-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[NUM_BITS-2:0], 1'b0};
			end
		end
	end
	assign stat.div_done = div_run_q && dcnt_q == DCNT_BITS'(1);

	// result
	logic [MEAN_BITS-1:0] mean_c;
	assign mean_c = (quo_q[NUM_BITS-1:MEAN_BITS] != '0) ? '1 : quo_q[MEAN_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.emit;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			box_mean <= err_q ? '0 : mean_c;
			in_band <= !err_q && mean_c >= low_q && mean_c <= high_q;
			query_error <= err_q;
		end
	end
endmodule

>>> sv/iibm_checker.sv
// iibm_checker: port level assertions for the box mean core
// depends on iibm_pkg; bound to integral_image_box_mean_core
module iibm_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic func,
	input logic result_valid,
	input logic in_band,
	input logic query_error,
	input logic cfg_ready
);
	import iibm_pkg::*;

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && func == FUNC_LOAD |=> ##1 !result_valid)
		else $error("load produced a result");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && func == FUNC_QUERY |=> busy)
		else $error("query transfer did not raise busy");

	a_err_band: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && query_error |-> !in_band)
		else $error("error result flagged in band");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready == !busy)
		else $error("config ready while busy");
endmodule

bind integral_image_box_mean_core iibm_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
	.result_valid(result_valid), .in_band(in_band), .query_error(query_error),
	.cfg_ready(cfg_ready)
);
